>>> sv/slp_pkg.sv
// Package for the sized literal parser: widths, character codes, state type, helpers.
package slp_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned SIZE_WIDTH  = 16;

  localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = {SIZE_WIDTH{1'b1}};

  // ASCII codes used by the parser
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPR_A = 8'h41;
  localparam logic [7:0] CH_UPR_F = 8'h46;
  localparam logic [7:0] CH_UPR_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LWR_A = 8'h61;
  localparam logic [7:0] CH_LWR_F = 8'h66;
  localparam logic [7:0] CH_LWR_B = 8'h62;
  localparam logic [7:0] CH_LWR_O = 8'h6F;
  localparam logic [7:0] CH_LWR_D = 8'h64;
  localparam logic [7:0] CH_LWR_H = 8'h68;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Base select codes
  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  // Hex value of a non-hex character
  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef enum logic [2:0] {
    PH_SIZE   = 3'b001,
    PH_LETTER = 3'b010,
    PH_DIGITS = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [SIZE_WIDTH-1:0]  size_accum;
    logic [VALUE_WIDTH-1:0] value_accum;
    logic                   saw_size;
    logic                   saw_digit;
    logic                   e_size;
    logic                   e_letter;
    logic                   e_range;
    logic                   e_ovf;
  } state_t;

  localparam state_t STATE_INIT = '{
    phase:       PH_SIZE,
    size_accum:  '0,
    value_accum: '0,
    saw_size:    1'b0,
    saw_digit:   1'b0,
    e_size:      1'b0,
    e_letter:    1'b0,
    e_range:     1'b0,
    e_ovf:       1'b0
  };

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 5'(c - CH_ZERO);
    end else if (c >= CH_LWR_A && c <= CH_LWR_F) begin
      v = 5'(c - CH_LWR_A) + 5'd10;
    end else if (c >= CH_UPR_A && c <= CH_UPR_F) begin
      v = 5'(c - CH_UPR_A) + 5'd10;
    end
    return v;
  endfunction

  function automatic logic [7:0] base_letter(input logic [1:0] sel);
    logic [7:0] l;
    case (sel)
      BASE_BIN: l = CH_LWR_B;
      BASE_OCT: l = CH_LWR_O;
      BASE_DEC: l = CH_LWR_D;
      default:  l = CH_LWR_H;
    endcase
    return l;
  endfunction

  function automatic logic [4:0] base_radix(input logic [1:0] sel);
    logic [4:0] r;
    case (sel)
      BASE_BIN: r = 5'd2;
      BASE_OCT: r = 5'd8;
      BASE_DEC: r = 5'd10;
      default:  r = 5'd16;
    endcase
    return r;
  endfunction

endpackage

>>> sv/slp_if.sv
// Channel interfaces: character input and parsed result output.
interface slp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [1:0] base_select;
  logic       last_char;

  modport source (output valid, char_code, base_select, last_char, input ready);
  modport sink   (input valid, char_code, base_select, last_char, output ready);
endinterface

interface slp_out_if;
  logic                           valid;
  logic                           ready;
  logic [slp_pkg::SIZE_WIDTH-1:0]  literal_size;
  logic [slp_pkg::VALUE_WIDTH-1:0] literal_value;
  logic                           err_no_apostrophe;
  logic                           err_size_field;
  logic                           err_base_letter;
  logic                           err_no_digits;
  logic                           err_digit_range;
  logic                           err_overflow;

  modport source (
    output valid, literal_size, literal_value, err_no_apostrophe, err_size_field,
           err_base_letter, err_no_digits, err_digit_range, err_overflow,
    input  ready
  );
  modport sink (
    input  valid, literal_size, literal_value, err_no_apostrophe, err_size_field,
           err_base_letter, err_no_digits, err_digit_range, err_overflow,
    output ready
  );
endinterface

>>> sv/sized_literal_parser.sv
// Sized number literal parser top level: state register, result register, handshakes.
// Output timing: the result of a literal is registered and appears on the output in
//   the cycle after its last character is accepted.
// Throughput: one character per cycle; the input stalls only while a finished
//   result is held and the output side is not taking it.
// Reset (rst, synchronous): parser returns to the size phase with all
//   accumulators and error flags cleared; the result register is emptied.
module sized_literal_parser (
  input  logic             clk,
  input  logic             rst,
  slp_in_if.sink           chars,
  slp_out_if.source        result
);

  // Parser state as it stands before the next character
  slp_pkg::state_t state;
  // State after applying the character currently offered
  slp_pkg::state_t state_next;

  // Result register; holds one finished literal until the sink takes it
  logic            out_valid;
  slp_pkg::state_t out_state;

  logic accept;

  slp_step u_step (
    .state       (state),
    .char_code   (chars.char_code),
    .base_select (chars.base_select),
    .state_next  (state_next)
  );

  // A new character may enter whenever the result register is empty or being
  // drained in this same cycle.
  assign chars.ready = !out_valid || result.ready;
  assign accept      = chars.valid && chars.ready;

  // Parser state: a last character closes the literal, so the state goes back
  // to its initial value ready for the next literal on the very next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slp_pkg::STATE_INIT;
    end else if (accept) begin
      if (chars.last_char) begin
        state <= slp_pkg::STATE_INIT;
      end else begin
        state <= state_next;
      end
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && chars.last_char) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: the final state of the literal, flags decoded on output
  always_ff @(posedge clk) begin
    if (accept && chars.last_char) begin
      out_state <= state_next;
    end
  end

  assign result.valid             = out_valid;
  assign result.literal_size      = out_state.size_accum;
  assign result.literal_value     = out_state.value_accum;
  assign result.err_no_apostrophe = (out_state.phase == slp_pkg::PH_SIZE);
  assign result.err_size_field    = out_state.e_size || !out_state.saw_size;
  assign result.err_base_letter   = out_state.e_letter;
  assign result.err_no_digits     = !out_state.saw_digit;
  assign result.err_digit_range   = out_state.e_range;
  assign result.err_overflow      = out_state.e_ovf;

`ifndef SYNTHESIS
  // After a literal closes, the parser starts over from a clean state
  a_restart_clean: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.last_char) |=>
      (state.phase == slp_pkg::PH_SIZE && state.size_accum == '0 &&
       state.value_accum == '0 && !state.e_ovf))
    else $error("parser state not cleared after last character");

  // A literal without an apostrophe can never have digits
  a_noapos_nodigits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.err_no_apostrophe) |-> result.err_no_digits)
    else $error("digits reported without an apostrophe");

  // Overflow needs at least one digit
  a_ovf_has_digits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.err_overflow) |-> !result.err_no_digits)
    else $error("overflow flagged with no digits");

  // No digits means the value is still zero
  a_nodigits_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.err_no_digits) |-> (result.literal_value == '0))
    else $error("nonzero value with no digits");
`endif

endmodule

>>> sv/slp_step.sv
// One-character update of the parser state (combinational).
module slp_step (
  input  slp_pkg::state_t state,
  input  logic [7:0]      char_code,
  input  logic [1:0]      base_select,
  output slp_pkg::state_t state_next
);

  localparam int unsigned SW = slp_pkg::SIZE_WIDTH;
  localparam int unsigned VW = slp_pkg::VALUE_WIDTH;

  logic [3:0]    size_digit;
  logic [SW+3:0] size_ext;
  logic [SW+3:0] size_prod;
  logic [7:0]    lower_char;
  logic [4:0]    hex_v;
  logic [3:0]    num_digit;
  logic [VW+3:0] value_ext;
  logic [VW+3:0] value_shift;
  logic [VW+3:0] value_prod;

  always_comb begin
    size_digit = 4'(char_code - slp_pkg::CH_ZERO);
    size_ext   = {4'b0, state.size_accum};
    size_prod  = (size_ext << 3) + (size_ext << 1) + (SW+4)'(size_digit);

    lower_char = (char_code >= slp_pkg::CH_UPR_A && char_code <= slp_pkg::CH_UPR_Z)
               ? char_code + slp_pkg::CASE_OFS : char_code;

    hex_v     = slp_pkg::hex_value(char_code);
    num_digit = (hex_v == slp_pkg::HEX_NONE) ? 4'd0 : hex_v[3:0];
    value_ext = {4'b0, state.value_accum};
    case (base_select)
      slp_pkg::BASE_BIN: value_shift = value_ext << 1;
      slp_pkg::BASE_OCT: value_shift = value_ext << 3;
      slp_pkg::BASE_DEC: value_shift = (value_ext << 3) + (value_ext << 1);
      default:           value_shift = value_ext << 4;
    endcase
    value_prod = value_shift + (VW+4)'(num_digit);
  end

  always_comb begin
    state_next = state;
    case (state.phase)
      slp_pkg::PH_SIZE: begin
        if (char_code == slp_pkg::CH_APOS) begin
          state_next.phase = slp_pkg::PH_LETTER;
        end else if (char_code inside {[slp_pkg::CH_ZERO:slp_pkg::CH_NINE]}) begin
          state_next.saw_size = 1'b1;
          if (size_prod[SW+3:SW] != 4'd0) begin
            state_next.size_accum = slp_pkg::SIZE_MAX;
            state_next.e_size     = 1'b1;
          end else begin
            state_next.size_accum = size_prod[SW-1:0];
          end
        end else begin
          state_next.e_size = 1'b1;
        end
      end
      slp_pkg::PH_LETTER: begin
        if (lower_char == slp_pkg::base_letter(base_select)) begin
          state_next.phase = slp_pkg::PH_DIGITS;
        end else begin
          state_next.e_letter = 1'b1;
        end
      end
      default: begin
        if (char_code != slp_pkg::CH_UNDER) begin
          state_next.saw_digit = 1'b1;
          if (hex_v >= slp_pkg::base_radix(base_select)) begin
            state_next.e_range = 1'b1;
          end
          if (value_prod[VW+3:VW] != 4'd0) begin
            state_next.e_ovf = 1'b1;
          end
          state_next.value_accum = value_prod[VW-1:0];
        end
      end
    endcase
  end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the sized number literal parser.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CHARS = 1600;    // rough size of the random part, in characters
  localparam int DRAIN_SPACING = 400;    // characters between forced drains
  localparam int MAX_GAP = 12;           // longest idle or stall drawn per transaction
  localparam int TAIL_CYCLES = 8;        // quiet time after the last result
  localparam int CYCLE_LIMIT = 300000;   // generous watchdog

  // One character transaction on the input channel. drain holds the character back
  // until every literal in flight has been reported.
  typedef struct {
    logic [7:0] code;
    logic [1:0] base;
    logic       last;
    bit         drain;
  } char_item_t;

  // One parsed literal as reported on the output channel.
  typedef struct {
    logic [slp_pkg::SIZE_WIDTH-1:0]  size;
    logic [slp_pkg::VALUE_WIDTH-1:0] value;
    logic                            no_apos;
    logic                            size_field;
    logic                            bad_letter;
    logic                            no_digits;
    logic                            digit_range;
    logic                            overflow;
  } literal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slp_in_if  chars ();
  slp_out_if result ();

  sized_literal_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .result (result)
  );

  always #5 clk = ~clk;

  char_item_t pending_chars[$];      // characters still to be sent
  literal_t   expected_literals[$];  // literals predicted but not yet reported
  int         fail_count = 0;
  int         cycle_count = 0;

  // Driver and monitor pacing; burst mode means no idling at all for a stretch.
  int tx_wait = 0;
  int rx_wait = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  // --------------------------------------------------------------------------
  // Parser model: phase, decimal size, value and sticky error flags.
  // --------------------------------------------------------------------------
  slp_pkg::phase_t                 cur_phase;
  logic [slp_pkg::SIZE_WIDTH-1:0]  size_acc;
  logic [slp_pkg::VALUE_WIDTH-1:0] value_acc;
  bit                              got_size_digit;
  bit                              got_value_digit;
  bit                              size_err;
  bit                              letter_err;
  bit                              range_err;
  bit                              ovf_err;

  function automatic void clear_parse();
    cur_phase       = slp_pkg::PH_SIZE;
    size_acc        = '0;
    value_acc       = '0;
    got_size_digit  = 1'b0;
    got_value_digit = 1'b0;
    size_err        = 1'b0;
    letter_err      = 1'b0;
    range_err       = 1'b0;
    ovf_err         = 1'b0;
  endfunction

  function automatic logic [7:0] letter_of(input logic [1:0] sel);
    case (sel)
      slp_pkg::BASE_BIN: return slp_pkg::CH_LWR_B;
      slp_pkg::BASE_OCT: return slp_pkg::CH_LWR_O;
      slp_pkg::BASE_DEC: return slp_pkg::CH_LWR_D;
      default:           return slp_pkg::CH_LWR_H;
    endcase
  endfunction

  function automatic int unsigned radix_of(input logic [1:0] sel);
    case (sel)
      slp_pkg::BASE_BIN: return 2;
      slp_pkg::BASE_OCT: return 8;
      slp_pkg::BASE_DEC: return 10;
      default:           return 16;
    endcase
  endfunction

  // Advances the model by one character; returns 1 and the literal on a last character.
  function automatic bit parse_char(input char_item_t it, output literal_t lit);
    logic [7:0]  folded;
    logic [63:0] wide;
    int unsigned dig;
    int unsigned radix;
    lit = '{default: '0};
    case (cur_phase)
      slp_pkg::PH_SIZE: begin
        if (it.code == slp_pkg::CH_APOS) begin
          cur_phase = slp_pkg::PH_LETTER;
        end else if (it.code >= slp_pkg::CH_ZERO && it.code <= slp_pkg::CH_NINE) begin
          got_size_digit = 1'b1;
          wide = 64'(size_acc) * 64'd10 + 64'(it.code - slp_pkg::CH_ZERO);
          // saturate instead of wrapping, and flag it
          if (wide > 64'(slp_pkg::SIZE_MAX)) begin
            size_acc = slp_pkg::SIZE_MAX;
            size_err = 1'b1;
          end else begin
            size_acc = wide[slp_pkg::SIZE_WIDTH-1:0];
          end
        end else begin
          size_err = 1'b1;
        end
      end
      slp_pkg::PH_LETTER: begin
        // base letters match in either case
        folded = (it.code >= slp_pkg::CH_UPR_A && it.code <= slp_pkg::CH_UPR_Z)
               ? it.code + slp_pkg::CASE_OFS : it.code;
        if (folded == letter_of(it.base)) begin
          cur_phase = slp_pkg::PH_DIGITS;
        end else begin
          letter_err = 1'b1;
        end
      end
      default: begin
        if (it.code != slp_pkg::CH_UNDER) begin
          radix = radix_of(it.base);
          if (it.code >= slp_pkg::CH_ZERO && it.code <= slp_pkg::CH_NINE) begin
            dig = it.code - slp_pkg::CH_ZERO;
          end else if (it.code >= slp_pkg::CH_LWR_A && it.code <= slp_pkg::CH_LWR_F) begin
            dig = it.code - slp_pkg::CH_LWR_A + 10;
          end else if (it.code >= slp_pkg::CH_UPR_A && it.code <= slp_pkg::CH_UPR_F) begin
            dig = it.code - slp_pkg::CH_UPR_A + 10;
          end else begin
            dig = slp_pkg::HEX_NONE;
          end
          // non-hex characters count as a zero digit; digits past the radix keep face value
          if (dig == slp_pkg::HEX_NONE) begin
            dig = 0;
            range_err = 1'b1;
          end else if (dig >= radix) begin
            range_err = 1'b1;
          end
          got_value_digit = 1'b1;
          wide = 64'(value_acc) * 64'(radix) + 64'(dig);
          if ((wide >> slp_pkg::VALUE_WIDTH) != 0) ovf_err = 1'b1;
          value_acc = wide[slp_pkg::VALUE_WIDTH-1:0];
        end
      end
    endcase
    if (!it.last) return 1'b0;
    lit.size        = size_acc;
    lit.value       = value_acc;
    lit.no_apos     = (cur_phase == slp_pkg::PH_SIZE);
    lit.size_field  = size_err || !got_size_digit;
    lit.bad_letter  = letter_err;
    lit.no_digits   = !got_value_digit;
    lit.digit_range = range_err;
    lit.overflow    = ovf_err;
    clear_parse();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_chars(input logic [7:0] text[$], input logic [1:0] base,
                            input bit mixed, input bit drain);
    char_item_t it;
    for (int i = 0; i < text.size(); i++) begin
      it.code  = text[i];
      it.base  = mixed ? 2'($urandom_range(0, 3)) : base;
      it.last  = (i == text.size() - 1);
      it.drain = drain && (i == 0);
      pending_chars.push_back(it);
    end
  endtask

  task automatic push_string(input string s, input logic [1:0] base);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    push_chars(text, base, 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return slp_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? slp_pkg::CH_LWR_A : slp_pkg::CH_UPR_A) + 8'(v - 10);
  endfunction

  // Mostly well-formed literals with random content; the rest is raw noise or
  // a well-formed literal cut short.
  task automatic add_random_literal(input bit drain);
    logic [7:0]  text[$];
    logic [7:0]  letter;
    logic [1:0]  base;
    int unsigned kind;
    int unsigned n;
    int unsigned maxd;
    int unsigned pick;
    base = 2'($urandom_range(0, 3));
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      // size: usually short, sometimes long enough to saturate, rarely absent
      if ($urandom_range(0, 19) != 0) begin
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2);
        repeat (n) text.push_back(slp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 19) == 0) text.push_back(8'($urandom_range(0, 255)));
      text.push_back(slp_pkg::CH_APOS);
      // stray character where the base letter belongs
      if ($urandom_range(0, 9) == 0) begin
        text.push_back($urandom_range(0, 1) ? slp_pkg::CH_APOS : 8'($urandom_range(0, 255)));
      end
      letter = letter_of(base);
      text.push_back($urandom_range(0, 1) ? letter : letter - slp_pkg::CASE_OFS);
      case (base)
        slp_pkg::BASE_BIN: maxd = 32;
        slp_pkg::BASE_OCT: maxd = 11;
        slp_pkg::BASE_DEC: maxd = 10;
        default:           maxd = 8;
      endcase
      // a few run past the width to hit overflow
      n = ($urandom_range(0, 7) == 0) ? maxd + $urandom_range(1, 4) : $urandom_range(1, maxd);
      if ($urandom_range(0, 19) == 0) n = 0;
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) text.push_back(slp_pkg::CH_UNDER);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          text.push_back(8'($urandom_range(0, 255)));
        end else if (pick == 1) begin
          text.push_back(digit_char($urandom_range(0, 15)));
        end else begin
          text.push_back(digit_char($urandom_range(0, radix_of(base) - 1)));
        end
      end
      if (kind == 1) begin
        n = $urandom_range(1, text.size());
        text = text[0:n-1];
      end
    end
    push_chars(text, base, $urandom_range(0, 19) == 0, drain);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents pending characters with random idle gaps. The model is
  // advanced at the edge where a transaction completes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    char_item_t head;
    literal_t   lit;
    bit         show;
    if (rst) begin
      chars.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      show = chars.valid;
      if (chars.valid && chars.ready) begin
        head = pending_chars.pop_front();
        if (parse_char(head, lit)) expected_literals.push_back(lit);
        show = 1'b0;
        tx_wait = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
      end
      if (!show) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_chars.size() != 0 &&
                     !(pending_chars[0].drain && expected_literals.size() != 0)) begin
          show = 1'b1;
          chars.char_code   <= pending_chars[0].code;
          chars.base_select <= pending_chars[0].base;
          chars.last_char   <= pending_chars[0].last;
        end
      end
      chars.valid <= show;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, in-order comparison against predictions.
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    literal_t want;
    if (rst) begin
      result.ready <= 1'b0;
      rx_wait = 0;
    end else if (result.valid && result.ready) begin
      if (expected_literals.size() == 0) begin
        $error("result transaction with no literal outstanding");
        fail_count++;
      end else begin
        want = expected_literals.pop_front();
        check_field("literal_size", want.size, result.literal_size);
        check_field("literal_value", want.value, result.literal_value);
        check_field("err_no_apostrophe", want.no_apos, result.err_no_apostrophe);
        check_field("err_size_field", want.size_field, result.err_size_field);
        check_field("err_base_letter", want.bad_letter, result.err_base_letter);
        check_field("err_no_digits", want.no_digits, result.err_no_digits);
        check_field("err_digit_range", want.digit_range, result.err_digit_range);
        check_field("err_overflow", want.overflow, result.err_overflow);
      end
      rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      result.ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      result.ready <= (rx_wait == 0);
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: fill the queue, reset, wait for everything to drain, report.
  // --------------------------------------------------------------------------
  initial begin
    int directed_count;
    int drain_mark;
    chars.valid       = 1'b0;
    chars.char_code   = '0;
    chars.base_select = slp_pkg::BASE_BIN;
    chars.last_char   = 1'b0;
    result.ready      = 1'b0;
    clear_parse();

    // Directed part
    push_string("8'hA_5", slp_pkg::BASE_HEX);        // plain literal with an underscore
    push_chars('{8'hFF}, slp_pkg::BASE_BIN, 1'b0, 1'b0);  // top code, no apostrophe
    push_chars('{8'h00}, slp_pkg::BASE_OCT, 1'b0, 1'b0);  // bottom code, no apostrophe
    push_string("'", slp_pkg::BASE_DEC);             // empty size, ends before the letter
    push_string("70000'Xb1", slp_pkg::BASE_BIN);     // saturated size, wrong letter skipped
    push_string("1'DZ9", slp_pkg::BASE_DEC);         // upper-case letter, non-hex digit
    push_string("2'o8", slp_pkg::BASE_OCT);          // digit past the radix
    directed_count = pending_chars.size();

    // Random part; the first random literal waits for the directed results
    drain_mark = directed_count;
    while (pending_chars.size() < directed_count + RANDOM_CHARS) begin
      if (pending_chars.size() >= drain_mark) begin
        add_random_literal(1'b1);
        drain_mark += DRAIN_SPACING;
      end else begin
        add_random_literal(1'b0);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    while (expected_literals.size() != 0) @(posedge clk);
    // let any spurious extra result show up
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
